[sv/bfpu_pkg.sv]
// Shared types, constants and mask helpers for the bitfield pixel unpacker.
package bfpu_pkg;

  localparam int NUM_CH    = 4;
  localparam int CH_RED    = 0;
  localparam int CH_GREEN  = 1;
  localparam int CH_BLUE   = 2;
  localparam int CH_ALPHA  = 3;

  localparam int WORD_W    = 32;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int HB_W      = 5;   // bit position inside a word
  localparam int CNT_W     = 6;   // ones count, 0..32
  localparam int WID_W     = 4;   // ones count clamped to 8

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_RED_MASK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GREEN_MASK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLUE_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA_MASK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIXTEEN    = 3'd4;

  localparam logic [WORD_W-1:0] RST_RED_MASK   = 32'h0000_7C00;
  localparam logic [WORD_W-1:0] RST_GREEN_MASK = 32'h0000_03E0;
  localparam logic [WORD_W-1:0] RST_BLUE_MASK  = 32'h0000_001F;
  localparam logic [WORD_W-1:0] RST_ALPHA_MASK = 32'h0000_0000;

  localparam logic [WORD_W-1:0] POP_M1 = 32'h5555_5555;
  localparam logic [WORD_W-1:0] POP_M2 = 32'h3333_3333;
  localparam logic [WORD_W-1:0] POP_M4 = 32'h0f0f_0f0f;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef logic [NUM_CH-1:0][WORD_W-1:0] mask_set_t;

  // position of the highest set bit, 0 for a zero mask
  function automatic logic [HB_W-1:0] top_one(input logic [WORD_W-1:0] m);
    logic [HB_W-1:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (m[i]) n = HB_W'(i);
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] ones_count(input logic [WORD_W-1:0] m);
    logic [WORD_W-1:0] a;
    a = (m & POP_M1) + ((m >> 1) & POP_M1);
    a = (a & POP_M2) + ((a >> 2) & POP_M2);
    a = (a + (a >> 4)) & POP_M4;
    a = a + (a >> 8);
    a = a + (a >> 16);
    return a[CNT_W-1:0];
  endfunction

endpackage

[sv/bitfield_pixel_unpack.sv]
// Bitfield pixel unpacker: packed 16/32-bit pixel words to 8-bit RGBA.
//
// Pixel words come in on the s_axis channel, one per tdata word, and leave
// as RGBA on m_axis (red in the low byte, alpha in the high byte) with the
// mask error flag in tuser. Channel masks and the 16-bit mode are set on
// the cfg channel (index 0..4: red, green, blue, alpha mask, 16-bit mode);
// cfg_ready is always high and writes belong to idle periods only.
//
// Three register stages: field select, align shift, bit replication. A
// word taken on s_axis moves through the field, aligned and chan registers
// to m_axis, and one word is taken every cycle as long as m_axis_tready
// stays high. When the receiver stalls, the stages fill up behind the held
// output word and s_axis_tready drops only when every stage holds a word;
// nothing is lost. Per-mask shift and width are recomputed from the mask
// registers every cycle, so they settle in the cycle after a config write.
//
// A synchronous reset empties the pipeline and loads the masks for
// 5:5:5 RGB in 16-bit words with constant opaque alpha.
module bitfield_pixel_unpack (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [bfpu_pkg::WORD_W-1:0]          s_axis_tdata,   // [31:0] pixel_word
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [bfpu_pkg::NUM_CH*bfpu_pkg::CHAN_W-1:0] m_axis_tdata,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [31:24] alpha_out
  output logic                                 m_axis_tuser,   // [0] mask_error
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bfpu_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfpu_pkg::WORD_W-1:0]          cfg_data
);

  localparam int NCH = bfpu_pkg::NUM_CH;
  localparam int CW  = bfpu_pkg::CHAN_W;
  localparam int WW  = bfpu_pkg::WORD_W;

  // configuration registers
  bfpu_pkg::mask_set_t mask;
  logic                sixteen;

  // derived per-mask values
  logic [NCH-1:0][bfpu_pkg::HB_W-1:0]  hb;
  logic [NCH-1:0][bfpu_pkg::WID_W-1:0] wid;
  logic                                color_err;
  logic                                alpha_zero;

  // pipeline
  logic                     v1, v2, v3;
  logic                     adv1, adv2, adv3;
  logic [NCH-1:0][WW-1:0]   field;
  logic [NCH-1:0][CW-1:0]   aligned;
  logic [NCH-1:0][CW-1:0]   aligned_next;
  logic [NCH-1:0][CW-1:0]   chan;
  logic [NCH-1:0][CW-1:0]   chan_next;
  logic                     err;
  logic [WW-1:0]            word_in;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask[bfpu_pkg::CH_RED]   <= bfpu_pkg::RST_RED_MASK;
      mask[bfpu_pkg::CH_GREEN] <= bfpu_pkg::RST_GREEN_MASK;
      mask[bfpu_pkg::CH_BLUE]  <= bfpu_pkg::RST_BLUE_MASK;
      mask[bfpu_pkg::CH_ALPHA] <= bfpu_pkg::RST_ALPHA_MASK;
      sixteen                  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bfpu_pkg::REG_RED_MASK:   mask[bfpu_pkg::CH_RED]   <= cfg_data;
        bfpu_pkg::REG_GREEN_MASK: mask[bfpu_pkg::CH_GREEN] <= cfg_data;
        bfpu_pkg::REG_BLUE_MASK:  mask[bfpu_pkg::CH_BLUE]  <= cfg_data;
        bfpu_pkg::REG_ALPHA_MASK: mask[bfpu_pkg::CH_ALPHA] <= cfg_data;
        bfpu_pkg::REG_SIXTEEN:    sixteen                  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // width clamped to 8: wider fields need no replication
  always_ff @(posedge clk) begin
    for (int c = 0; c < NCH; c++) begin
      hb[c]  <= bfpu_pkg::top_one(mask[c]);
      wid[c] <= (bfpu_pkg::ones_count(mask[c]) > bfpu_pkg::CNT_W'(CW))
                ? bfpu_pkg::WID_W'(CW)
                : bfpu_pkg::WID_W'(bfpu_pkg::ones_count(mask[c]));
    end
    color_err  <= (mask[bfpu_pkg::CH_RED] == '0) || (mask[bfpu_pkg::CH_GREEN] == '0) ||
                  (mask[bfpu_pkg::CH_BLUE] == '0);
    alpha_zero <= (mask[bfpu_pkg::CH_ALPHA] == '0);
  end

  // stall handling: a stage moves when it is empty or the next one moves
  assign adv3          = !v3 || m_axis_tready;
  assign adv2          = !v2 || adv3;
  assign adv1          = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= s_axis_tvalid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  assign word_in = sixteen ? {{(WW-16){1'b0}}, s_axis_tdata[15:0]} : s_axis_tdata;

  // stage 1: field select
  always_ff @(posedge clk) begin
    if (adv1 && s_axis_tvalid) begin
      for (int c = 0; c < NCH; c++) field[c] <= word_in & mask[c];
    end
  end

  // stage 2: move the field's top bit to bit 7
  always_comb begin
    logic [WW+CW-2:0] ext;
    ext = '0;
    for (int c = 0; c < NCH; c++) begin
      ext             = {field[c], {(CW-1){1'b0}}} >> hb[c];
      aligned_next[c] = ext[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && v1) aligned <= aligned_next;
  end

  // stage 3: replicate the field downward, sum wraps at 8 bits
  always_comb begin
    logic [CW-1:0] acc;
    logic [6:0]    sh;
    acc = '0;
    sh  = '0;
    for (int c = 0; c < NCH; c++) begin
      acc = aligned[c];
      for (int k = 1; k < CW; k++) begin
        sh = 7'(k) * 7'(wid[c]);
        if (sh < 7'(CW)) acc = acc + (aligned[c] >> sh[2:0]);
      end
      chan_next[c] = acc;
    end
    if (alpha_zero) chan_next[bfpu_pkg::CH_ALPHA] = bfpu_pkg::ALPHA_OPAQUE;
    if (color_err) chan_next = '0;
  end

  always_ff @(posedge clk) begin
    if (adv3 && v2) begin
      chan <= chan_next;
      err  <= color_err;
    end
  end

  assign m_axis_tvalid = v3;
  assign m_axis_tdata  = chan;
  assign m_axis_tuser  = err;

endmodule

[sv/bfpu_checker.sv]
// Port-level checker for the bitfield pixel unpacker, bound to the top level.
module bfpu_checker (
  input logic                                          clk,
  input logic                                          rst,
  input logic                                          s_axis_tready,
  input logic                                          m_axis_tvalid,
  input logic                                          m_axis_tready,
  input logic [bfpu_pkg::NUM_CH*bfpu_pkg::CHAN_W-1:0]  m_axis_tdata,
  input logic                                          m_axis_tuser
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid right after reset");

  // a stalled output word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // input backpressure only while the output itself is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with a free pipeline");

  // a mask error word carries all-zero channels
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("mask error word with nonzero channels");

endmodule

bind bitfield_pixel_unpack bfpu_checker u_bfpu_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

[tb/tb_top.sv]
// Self-checking testbench for the bitfield pixel unpacker: random masks, pixels and stalls.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [bfpu_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PIXELS = 380;

  typedef struct packed {
    logic [bfpu_pkg::CHAN_W-1:0] red;
    logic [bfpu_pkg::CHAN_W-1:0] green;
    logic [bfpu_pkg::CHAN_W-1:0] blue;
    logic [bfpu_pkg::CHAN_W-1:0] alpha;
    logic                        mask_error;
  } rgba_t;

  logic                                         clk;
  logic                                         rst;
  logic                                         s_axis_tvalid;
  logic                                         s_axis_tready;
  logic [bfpu_pkg::WORD_W-1:0]                  s_axis_tdata;
  logic                                         m_axis_tvalid;
  logic                                         m_axis_tready;
  logic [bfpu_pkg::NUM_CH*bfpu_pkg::CHAN_W-1:0] m_axis_tdata;
  logic                                         m_axis_tuser;
  logic                                         cfg_valid;
  logic                                         cfg_ready;
  logic [bfpu_pkg::CFG_IDX_W-1:0]               cfg_index;
  logic [bfpu_pkg::WORD_W-1:0]                  cfg_data;

  // local copy of the mask registers
  logic [bfpu_pkg::WORD_W-1:0] red_mask_q, green_mask_q, blue_mask_q, alpha_mask_q;
  logic                        sixteen_q;

  logic [bfpu_pkg::WORD_W-1:0] pending_pixels[$];
  rgba_t                       expected_rgba[$];
  bit                          pixel_taken;
  bit                          calm;
  int                          src_gap, snk_gap;
  int                          failures;
  int                          random_sent;

  bitfield_pixel_unpack dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #10 clk = ~clk;

  // align the masked field so its top bit sits at bit 7, then replicate down
  function automatic logic [bfpu_pkg::CHAN_W-1:0] expand_field(
      input logic [bfpu_pkg::WORD_W-1:0] word,
      input logic [bfpu_pkg::WORD_W-1:0] mask);
    logic [63:0] field, aligned, acc;
    int top, width;
    field = {32'h0, word & mask};
    top = 0;
    for (int i = 0; i < bfpu_pkg::WORD_W; i++) begin
      if (mask[i]) top = i;
    end
    width = $countones(mask);
    aligned = (top < 7) ? field << (7 - top) : field >> (top - 7);
    acc = aligned;
    for (int z = width; z < 8; z += width) acc += aligned >> z;
    return acc[bfpu_pkg::CHAN_W-1:0];
  endfunction

  function automatic rgba_t predict_rgba(input logic [bfpu_pkg::WORD_W-1:0] pixel);
    rgba_t r;
    logic [bfpu_pkg::WORD_W-1:0] w;
    w = sixteen_q ? {16'h0, pixel[15:0]} : pixel;
    r = '0;
    if (red_mask_q == '0 || green_mask_q == '0 || blue_mask_q == '0) begin
      r.mask_error = 1'b1;
    end else begin
      r.red   = expand_field(w, red_mask_q);
      r.green = expand_field(w, green_mask_q);
      r.blue  = expand_field(w, blue_mask_q);
      r.alpha = (alpha_mask_q == '0) ? bfpu_pkg::ALPHA_OPAQUE
                                     : expand_field(w, alpha_mask_q);
    end
    return r;
  endfunction

  function automatic logic [bfpu_pkg::WORD_W-1:0] pick_mask();
    int w;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        w = $urandom_range(1, 12);
        return (32'hFFFF_FFFF >> (32 - w)) << $urandom_range(0, 32 - w);
      end
      4, 5:    return $urandom;
      6:       return 32'h1 << $urandom_range(0, 31);
      7:       return 32'hFFFF_FFFF;
      8:       return $urandom & 32'h0000_FFFF;
      default: return '0;
    endcase
  endfunction

  task automatic cfg_write(input logic [bfpu_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bfpu_pkg::WORD_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      bfpu_pkg::REG_RED_MASK:   red_mask_q   = data;
      bfpu_pkg::REG_GREEN_MASK: green_mask_q = data;
      bfpu_pkg::REG_BLUE_MASK:  blue_mask_q  = data;
      bfpu_pkg::REG_ALPHA_MASK: alpha_mask_q = data;
      bfpu_pkg::REG_SIXTEEN:    sixteen_q    = data[0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_valid <= 1'b0;
    // shift/width registers settle in the cycle after the write
    repeat (2) @(posedge clk);
  endtask

  // all words out of the pipe, then let the stages empty
  task automatic wait_idle();
    while (pending_pixels.size() != 0 || s_axis_tvalid || expected_rgba.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic [bfpu_pkg::WORD_W-1:0] r,
                           input logic [bfpu_pkg::WORD_W-1:0] g,
                           input logic [bfpu_pkg::WORD_W-1:0] b,
                           input logic [bfpu_pkg::WORD_W-1:0] a,
                           input logic s16);
    wait_idle();
    cfg_write(bfpu_pkg::REG_RED_MASK, r);
    cfg_write(bfpu_pkg::REG_GREEN_MASK, g);
    cfg_write(bfpu_pkg::REG_BLUE_MASK, b);
    cfg_write(bfpu_pkg::REG_ALPHA_MASK, a);
    cfg_write(bfpu_pkg::REG_SIXTEEN, {31'h0, s16});
    cfg_release();
  endtask

  // source side
  always @(negedge clk) begin
    if (!s_axis_tvalid || pixel_taken) begin
      pixel_taken = 1'b0;
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_pixels.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_pixels.pop_front();
      end
    end
  end

  // sink side
  always @(negedge clk) begin
    if (snk_gap > 0) begin
      snk_gap--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      snk_gap = $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    rgba_t want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_rgba.push_back(predict_rgba(s_axis_tdata));
        pixel_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_rgba.size() == 0) begin
          $error("result word with no pixel outstanding: tdata %h tuser %b",
                 m_axis_tdata, m_axis_tuser);
          failures++;
        end else begin
          want = expected_rgba.pop_front();
          if (m_axis_tdata[7:0] !== want.red) begin
            $error("red_out: expected %0h, actual %0h", want.red, m_axis_tdata[7:0]);
            failures++;
          end
          if (m_axis_tdata[15:8] !== want.green) begin
            $error("green_out: expected %0h, actual %0h", want.green, m_axis_tdata[15:8]);
            failures++;
          end
          if (m_axis_tdata[23:16] !== want.blue) begin
            $error("blue_out: expected %0h, actual %0h", want.blue, m_axis_tdata[23:16]);
            failures++;
          end
          if (m_axis_tdata[31:24] !== want.alpha) begin
            $error("alpha_out: expected %0h, actual %0h", want.alpha, m_axis_tdata[31:24]);
            failures++;
          end
          if (m_axis_tuser !== want.mask_error) begin
            $error("mask_error: expected %0b, actual %0b", want.mask_error, m_axis_tuser);
            failures++;
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    clk = 1'b0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    pixel_taken = 1'b0;
    calm = 1'b0;
    src_gap = 0;
    snk_gap = 0;
    failures = 0;
    random_sent = 0;
    red_mask_q   = bfpu_pkg::RST_RED_MASK;
    green_mask_q = bfpu_pkg::RST_GREEN_MASK;
    blue_mask_q  = bfpu_pkg::RST_BLUE_MASK;
    alpha_mask_q = bfpu_pkg::RST_ALPHA_MASK;
    sixteen_q    = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset masks: 5:5:5 in 16-bit words, opaque alpha, upper half dropped
    pending_pixels = '{32'h0, 32'hFFFF_FFFF, 32'h0000_7C00, 32'hABCD_03E0, 32'h5555_AAAA};

    // 8:8:8:8 over full 32-bit words
    configure(32'h00FF_0000, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, 1'b0);
    pending_pixels = '{32'hFFFF_FFFF, 32'h0, 32'h8040_2010, 32'h7F80_01FE};

    // zero color mask flags an error
    configure(32'h0, 32'h0000_FF00, 32'h0000_00FF, 32'hFF00_0000, 1'b0);
    pending_pixels = '{32'hFFFF_FFFF, 32'h1234_5678};

    // masks above bit 15 in 16-bit mode see cleared bits
    configure(32'hF800_0000, 32'h07E0_0000, 32'h0000_F800, 32'hFFFF_0000, 1'b1);
    pending_pixels = '{32'hFFFF_FFFF, 32'hFFFF_0000, 32'h0000_A5A5};

    // scattered masks, one-bit field at bit 0, whole-word mask; then a dropped write
    configure(32'hA5A5_0F0F, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0001, 1'b0);
    cfg_write(REG_UNUSED, 32'h0);
    cfg_release();
    pending_pixels = '{32'hFFFF_FFFF, 32'h0000_0001, 32'hA5A5_0F0E, 32'h8000_0000};

    while (random_sent < RANDOM_PIXELS) begin
      configure(pick_mask(), pick_mask(), pick_mask(),
                ($urandom_range(0, 3) == 0) ? 32'h0 : pick_mask(),
                1'($urandom_range(0, 1)));
      n = $urandom_range(20, 60);
      repeat (n) pending_pixels.push_back($urandom);
      random_sent += n;
    end

    // final stretch at full rate: 5:6:5 with 4-bit alpha on top
    configure(32'h0000_F800, 32'h0000_07E0, 32'h0000_001F, 32'h000F_0000, 1'b0);
    calm = 1'b1;
    repeat (40) pending_pixels.push_back($urandom);

    wait_idle();
    repeat (10) @(posedge clk);
    if (expected_rgba.size() != 0) begin
      $error("%0d result words never arrived", expected_rgba.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
